/* rtl/hdlc_like_frame_receiver_defines.svh */
// Assertion macros for the frame receiver RTL.
`ifndef HDLC_LIKE_FRAME_RECEIVER_DEFINES_SVH
`define HDLC_LIKE_FRAME_RECEIVER_DEFINES_SVH

// Combinational implication checked at every clock edge outside reset.
`define HLFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hlfr assertion failed");

// Implication that must hold in the cycle after the antecedent.
`define HLFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hlfr assertion failed");

`endif

/* rtl/hlfr_pkg.sv */
// Types and constants of the frame receiver.
package hlfr_pkg;

	localparam logic [7:0] FLAG_BYTE    = 8'h7E;
	localparam logic [7:0] ESC_BYTE     = 8'h7D;
	localparam logic [7:0] ESC_FLAG     = 8'h5E;
	localparam logic [7:0] CTL_RR       = 8'h05;
	localparam logic [7:0] CTL_REJ      = 8'h01;
	localparam logic [7:0] CHECK_MASK   = 8'h03;
	localparam int         SEQ_BIT      = 6;
	localparam int         RECV_BIT_POS = 7;

	typedef enum logic [1:0] {
		VERDICT_NEW      = 2'd0,
		VERDICT_DUP      = 2'd1,
		VERDICT_HDR_ERR  = 2'd2,
		VERDICT_DATA_ERR = 2'd3
	} hlfr_verdict_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} hlfr_kind_t;

	typedef struct packed {
		hlfr_kind_t    kind;
		logic [7:0]    payload_byte;
		hlfr_verdict_t verdict;
		logic [7:0]    response_control;
		logic [7:0]    response_check;
	} hlfr_result_t;

endpackage

/* rtl/hlfr_frame.sv */
// Frame state: flag hunting, destuffing, header check, payload delay and verdict.
`include "hdlc_like_frame_receiver_defines.svh"

module hlfr_frame import hlfr_pkg::*; #(
	parameter int MAX_FRAME = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   byte_in,
	output logic         res_valid,
	output hlfr_result_t res
);

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	logic             in_frame_q, in_frame_d;
	logic             esc_q, esc_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       addr_q, addr_d;
	logic [7:0]       ctl_q, ctl_d;
	logic             hdr_ok_q, hdr_ok_d;
	logic [7:0]       held_q, held_d;
	logic             held_valid_q, held_valid_d;
	logic [7:0]       xor_q, xor_d;
	logic             rbit_q, rbit_d;
	logic             ovf_q, ovf_d;

	logic             is_flag;
	logic             take;
	logic [7:0]       data;
	logic             seq_bit;
	hlfr_verdict_t    vd;
	logic [7:0]       rctl;

	always_comb begin
		is_flag = (byte_in == FLAG_BYTE);
		seq_bit = ctl_q[SEQ_BIT];

		if (cnt_q < CNT_W'(3) || !hdr_ok_q) begin
			vd = VERDICT_HDR_ERR;
		end else if (seq_bit == rbit_q) begin
			vd = VERDICT_DUP;
		end else if (!ovf_q && held_valid_q && xor_q == held_q) begin
			vd = VERDICT_NEW;
		end else begin
			vd = VERDICT_DATA_ERR;
		end
		rctl = (vd == VERDICT_NEW || vd == VERDICT_DUP) ? CTL_RR : CTL_REJ;
		rctl[RECV_BIT_POS] = rbit_q;

		in_frame_d   = in_frame_q;
		esc_d        = esc_q;
		cnt_d        = cnt_q;
		addr_d       = addr_q;
		ctl_d        = ctl_q;
		hdr_ok_d     = hdr_ok_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		xor_d        = xor_q;
		rbit_d       = rbit_q;
		ovf_d        = ovf_q;
		res_valid    = 1'b0;
		res          = '0;
		take         = 1'b0;
		data         = byte_in;

		if (!in_frame_q) begin
			if (is_flag) begin
				in_frame_d = 1'b1;
			end
		end else if (is_flag) begin
			esc_d = 1'b0;
			if (cnt_q != '0) begin
				res_valid            = 1'b1;
				res.kind             = KIND_VERDICT;
				res.verdict          = vd;
				res.response_control = rctl;
				res.response_check   = CHECK_MASK ^ rctl;
				if (vd == VERDICT_NEW) begin
					rbit_d = ~rbit_q;
				end
				in_frame_d   = 1'b0;
				cnt_d        = '0;
				addr_d       = '0;
				ctl_d        = '0;
				hdr_ok_d     = 1'b0;
				held_d       = '0;
				held_valid_d = 1'b0;
				xor_d        = '0;
				ovf_d        = 1'b0;
			end
		end else if (esc_q) begin
			esc_d = 1'b0;
			take  = 1'b1;
			data  = (byte_in == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE;
		end else if (byte_in == ESC_BYTE) begin
			esc_d = 1'b1;
		end else begin
			take = 1'b1;
		end

		if (take) begin
			if (ovf_q || cnt_q == CNT_W'(MAX_FRAME)) begin
				ovf_d = 1'b1;
			end else begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(0)) begin
					addr_d = data;
				end else if (cnt_q == CNT_W'(1)) begin
					ctl_d = data;
				end else if (cnt_q == CNT_W'(2)) begin
					hdr_ok_d     = ((addr_q ^ ctl_q) == data);
					xor_d        = '0;
					held_valid_d = 1'b0;
				end else begin
					if (held_valid_q) begin
						xor_d = xor_q ^ held_q;
						if (hdr_ok_q) begin
							res_valid        = 1'b1;
							res.kind         = KIND_PAYLOAD;
							res.payload_byte = held_q;
						end
					end
					held_d       = data;
					held_valid_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			esc_q        <= 1'b0;
			cnt_q        <= '0;
			addr_q       <= '0;
			ctl_q        <= '0;
			hdr_ok_q     <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			xor_q        <= '0;
			rbit_q       <= 1'b1;
			ovf_q        <= 1'b0;
		end else if (step) begin
			in_frame_q   <= in_frame_d;
			esc_q        <= esc_d;
			cnt_q        <= cnt_d;
			addr_q       <= addr_d;
			ctl_q        <= ctl_d;
			hdr_ok_q     <= hdr_ok_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			xor_q        <= xor_d;
			rbit_q       <= rbit_d;
			ovf_q        <= ovf_d;
		end
	end

	`HLFR_ASSERT_NOW(a_esc_in_frame, clk, arst_n, !in_frame_q, !esc_q && cnt_q == '0)
	`HLFR_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_FRAME))
	`HLFR_ASSERT_NOW(a_held_cnt, clk, arst_n, held_valid_q, cnt_q > CNT_W'(3))
	`HLFR_ASSERT_NOW(a_ovf_full, clk, arst_n, ovf_q, cnt_q == CNT_W'(MAX_FRAME))

endmodule

/* rtl/hlfr_outreg.sv */
// Result register between the frame logic and the result channel.
module hlfr_outreg import hlfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_valid,
	input  hlfr_result_t load_data,
	output logic         can_load,
	output logic         valid,
	input  logic         stall,
	output hlfr_result_t data
);

	logic         valid_q;
	hlfr_result_t data_q;

	assign can_load = !valid_q || !stall;
	assign valid    = valid_q;
	assign data     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load_valid) begin
			data_q <= load_data;
		end
	end

endmodule

/* rtl/hdlc_like_frame_receiver.sv */
// Top level of the byte-stuffed frame receiver with stop-and-wait reply.
//  channel  dir   handshake             payload
//  rx       in    rx_valid / rx_stall   rx_byte
//  res      out   res_valid / res_stall kind, payload_byte, verdict,
//                                       response_control, response_check
// One byte per cycle while rx_stall is low: input register, one pass of frame logic, result register.
// An rx byte passes the input register, then the result register; a byte yields zero or one result.
// Reset clears frame state and sets the receive bit to one.
// rx_stall rises only while the input register holds a byte and the result
// register is full and stalled.
module hdlc_like_frame_receiver import hlfr_pkg::*; #(
	parameter int MAX_FRAME = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [1:0] verdict,
	output logic [7:0] response_control,
	output logic [7:0] response_check
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         can_load;
	logic         step;
	logic         fr_valid;
	hlfr_result_t fr_res;
	hlfr_result_t out_res;

	assign step     = valid_s1 && can_load;
	assign rx_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	hlfr_frame #(
		.MAX_FRAME(MAX_FRAME)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_in  (byte_s1),
		.res_valid(fr_valid),
		.res      (fr_res)
	);

	hlfr_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(step && fr_valid),
		.load_data (fr_res),
		.can_load  (can_load),
		.valid     (res_valid),
		.stall     (res_stall),
		.data      (out_res)
	);

	assign kind             = out_res.kind;
	assign payload_byte     = out_res.payload_byte;
	assign verdict          = out_res.verdict;
	assign response_control = out_res.response_control;
	assign response_check   = out_res.response_check;

endmodule

/* tb/testbench.sv */
// Testbench for hdlc_like_frame_receiver: directed frames, then random stuffed frames.
`timescale 1ns / 1ps

module testbench import hlfr_pkg::*; ();

	localparam int FRAME_LIMIT  = 256;
	localparam int LINE_TARGET  = 2000;
	localparam int LIMIT_CYCLES = 400000;

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_stall;
	logic [7:0] rx_byte;
	logic       res_valid;
	logic       res_stall;
	logic       kind;
	logic [7:0] payload_byte;
	logic [1:0] verdict;
	logic [7:0] response_control;
	logic [7:0] response_check;

	hdlc_like_frame_receiver #(.MAX_FRAME(FRAME_LIMIT)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.payload_byte(payload_byte),
		.verdict(verdict),
		.response_control(response_control),
		.response_check(response_check)
	);

	typedef struct {
		logic [7:0]    b;
		bit            typed;
		hlfr_verdict_t v;
		logic [7:0]    ctl;
		logic [7:0]    chk;
	} script_row_t;

	// Verdict rows carry the reply typed in; the rest go through the decoder model.
	script_row_t script [0:25] = '{
		'{8'h00, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7E, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7E, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h03, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h00, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h03, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7D, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h5E, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'hFF, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h81, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7E, 1'b1, VERDICT_NEW,      8'h85, 8'h86},
		'{8'h7E, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h01, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h00, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h01, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7E, 1'b1, VERDICT_DUP,      8'h05, 8'h06},
		'{8'h7E, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7D, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7E, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h55, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7E, 1'b1, VERDICT_HDR_ERR,  8'h01, 8'h02},
		'{8'h7E, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h00, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h40, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h40, 1'b0, VERDICT_NEW,      8'h00, 8'h00},
		'{8'h7E, 1'b1, VERDICT_DATA_ERR, 8'h01, 8'h02}
	};

	// decoder model state
	bit         in_frm;
	bit         esc_seen;
	int         dcount;
	logic [7:0] hdr_addr;
	logic [7:0] hdr_ctl;
	bit         hdr_good;
	logic [7:0] hold_byte;
	bit         hold_valid;
	logic [7:0] data_xor;
	bit         recv_bit;
	bit         too_long;

	hlfr_result_t frame_out_q [$];

	int  line_bytes = 0;
	int  frames_sent = 0;
	int  errors = 0;
	int  payload_seen = 0;
	int  verdict_seen [4] = '{0, 0, 0, 0};
	int  cycles = 0;
	bit  hold_rx = 1'b0;
	bit  quiet = 1'b0;
	bit  gaps_on = 1'b1;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void clear_frame();
		esc_seen = 1'b0;
		dcount = 0;
		hdr_addr = '0;
		hdr_ctl = '0;
		hdr_good = 1'b0;
		hold_byte = '0;
		hold_valid = 1'b0;
		data_xor = '0;
		too_long = 1'b0;
	endfunction

	// One destuffed byte into the frame; a delayed data byte may come out.
	function automatic bit absorb(input logic [7:0] d, inout hlfr_result_t r);
		bit got;
		got = 1'b0;
		if (too_long || dcount >= FRAME_LIMIT) begin
			too_long = 1'b1;
			return 1'b0;
		end
		case (dcount)
			0: hdr_addr = d;
			1: hdr_ctl = d;
			2: begin
				hdr_good = ((hdr_addr ^ hdr_ctl) == d);
				data_xor = '0;
				hold_valid = 1'b0;
			end
			default: begin
				if (hold_valid) begin
					data_xor ^= hold_byte;
					if (hdr_good) begin
						r.kind = KIND_PAYLOAD;
						r.payload_byte = hold_byte;
						got = 1'b1;
					end
				end
				hold_byte = d;
				hold_valid = 1'b1;
			end
		endcase
		dcount++;
		return got;
	endfunction

	// One raw line byte; returns 1 when the receiver owes an output for it.
	function automatic bit decode_line_byte(input logic [7:0] b, output hlfr_result_t r);
		hlfr_verdict_t v;
		logic [7:0]    ctl;
		r = '0;
		if (!in_frm) begin
			if (b == FLAG_BYTE) begin
				in_frm = 1'b1;
				clear_frame();
			end
			return 1'b0;
		end
		if (b == FLAG_BYTE) begin
			esc_seen = 1'b0;
			if (dcount == 0)
				return 1'b0;
			if (dcount < 3 || !hdr_good) begin
				v = VERDICT_HDR_ERR;
				ctl = CTL_REJ;
			end else if (hdr_ctl[SEQ_BIT] == recv_bit) begin
				v = VERDICT_DUP;
				ctl = CTL_RR;
			end else if (!too_long && hold_valid && data_xor == hold_byte) begin
				v = VERDICT_NEW;
				ctl = CTL_RR;
			end else begin
				v = VERDICT_DATA_ERR;
				ctl = CTL_REJ;
			end
			ctl[RECV_BIT_POS] = recv_bit;
			r.kind = KIND_VERDICT;
			r.verdict = v;
			r.response_control = ctl;
			r.response_check = CHECK_MASK ^ ctl;
			if (v == VERDICT_NEW)
				recv_bit = ~recv_bit;
			clear_frame();
			in_frm = 1'b0;
			return 1'b1;
		end
		if (esc_seen) begin
			esc_seen = 1'b0;
			return absorb((b == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE, r);
		end
		if (b == ESC_BYTE) begin
			esc_seen = 1'b1;
			return 1'b0;
		end
		return absorb(b, r);
	endfunction

	function automatic logic [7:0] rand_not(input logic [7:0] a, input logic [7:0] c);
		logic [7:0] x;
		do
			x = 8'($urandom);
		while (x == a || x == c);
		return x;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed,
		input hlfr_result_t typed_res);
		hlfr_result_t p;
		bit           got;
		if (!quiet && !hold_rx && gaps_on && $urandom_range(0, 5) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		if (in_frm || b == FLAG_BYTE)
			line_bytes++;
		got = decode_line_byte(b, p);
		if (typed)
			frame_out_q.push_back(typed_res);
		else if (got)
			frame_out_q.push_back(p);
	endtask

	task automatic send_raw(input logic [7:0] b);
		send_byte(b, 1'b0, '0);
	endtask

	// One random frame: mostly well formed, with header, check, sequence and length faults mixed in.
	task automatic send_frame();
		logic [7:0] d [$];
		logic [7:0] a, c, x, acc;
		int         pick, n;
		bit         good;
		pick = $urandom_range(0, 99);
		good = (pick < 45) || (pick >= 86);
		if ($urandom_range(0, 7) == 0)
			gaps_on = !gaps_on;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_raw(rand_not(FLAG_BYTE, FLAG_BYTE));
		repeat ($urandom_range(1, 3)) send_raw(FLAG_BYTE);
		if (pick >= 95) begin
			send_raw(ESC_BYTE);
			send_raw(FLAG_BYTE);
		end
		a = 8'($urandom);
		c = 8'($urandom);
		if (good)
			c[SEQ_BIT] = ~recv_bit;
		else if (pick < 55)
			c[SEQ_BIT] = recv_bit;
		d.push_back(a);
		d.push_back(c);
		d.push_back(a ^ c);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
		if (pick >= 83 && pick < 86) begin
			n = FRAME_LIMIT - 8 + $urandom_range(0, 12);
			c[SEQ_BIT] = ~recv_bit;
			d[1] = c;
			d[2] = a ^ c;
		end
		acc = '0;
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: x = FLAG_BYTE;
				1: x = ESC_BYTE;
				default: x = 8'($urandom);
			endcase
			d.push_back(x);
			acc ^= x;
		end
		if (pick >= 55 && pick < 63) begin
			d[2] = d[2] ^ (8'h01 << $urandom_range(0, 7));
			d.push_back(acc);
		end else if (pick >= 63 && pick < 71) begin
			d.push_back(acc ^ 8'($urandom_range(1, 255)));
		end else if (pick >= 71 && pick < 75) begin
			while (d.size() > 3) void'(d.pop_back());
		end else if (pick >= 75 && pick < 80) begin
			n = $urandom_range(1, 2);
			while (d.size() > n) void'(d.pop_back());
		end else if (pick >= 80 && pick < 83) begin
			d.delete();
			repeat ($urandom_range(1, 12)) d.push_back(8'($urandom));
		end else begin
			d.push_back(acc);
		end
		foreach (d[i]) begin
			if (d[i] == FLAG_BYTE) begin
				send_raw(ESC_BYTE);
				send_raw(ESC_FLAG);
			end else if (d[i] == ESC_BYTE) begin
				send_raw(ESC_BYTE);
				send_raw(rand_not(ESC_FLAG, FLAG_BYTE));
			end else begin
				send_raw(d[i]);
			end
		end
		if ($urandom_range(0, 9) == 0)
			send_raw(ESC_BYTE);
		send_raw(FLAG_BYTE);
		frames_sent++;
	endtask

	task automatic check_output(input hlfr_result_t got);
		hlfr_result_t want;
		bit           bad;
		bad = 1'b0;
		if (frame_out_q.size() == 0) begin
			$display("%0t: unexpected output: kind %0d byte %02h verdict %0d ctl %02h chk %02h",
				$time, got.kind, got.payload_byte, got.verdict, got.response_control,
				got.response_check);
			errors++;
		end else begin
			want = frame_out_q.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
				bad = 1'b1;
			end
			if (got.payload_byte !== want.payload_byte) begin
				$display("%0t: payload_byte expected %02h got %02h", $time,
					want.payload_byte, got.payload_byte);
				bad = 1'b1;
			end
			if (got.verdict !== want.verdict) begin
				$display("%0t: verdict expected %0d got %0d", $time, want.verdict, got.verdict);
				bad = 1'b1;
			end
			if (got.response_control !== want.response_control) begin
				$display("%0t: response_control expected %02h got %02h", $time,
					want.response_control, got.response_control);
				bad = 1'b1;
			end
			if (got.response_check !== want.response_check) begin
				$display("%0t: response_check expected %02h got %02h", $time,
					want.response_check, got.response_check);
				bad = 1'b1;
			end
			if (bad)
				errors++;
			if (want.kind == KIND_VERDICT)
				verdict_seen[want.verdict]++;
			else
				payload_seen++;
		end
	endtask

	// result side: checks each transfer, stalls in bursts
	initial begin : result_side
		int           burst;
		bit           bursts_on;
		hlfr_result_t got;
		burst = 0;
		bursts_on = 1'b1;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				got.kind = hlfr_kind_t'(kind);
				got.payload_byte = payload_byte;
				got.verdict = hlfr_verdict_t'(verdict);
				got.response_control = response_control;
				got.response_check = response_check;
				check_output(got);
			end
			if ($urandom_range(0, 199) == 0)
				bursts_on = !bursts_on;
			if (burst > 0)
				burst--;
			else if (bursts_on && !quiet && $urandom_range(0, 7) == 0)
				burst = $urandom_range(1, 7);
			res_stall <= hold_rx || (burst > 0 && !quiet);
		end
	end

	// long hold-off on the result side so the input backs up
	initial begin : long_hold
		wait (line_bytes >= 400);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (80) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin : line_side
		hlfr_result_t t;
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = '0;
		in_frm = 1'b0;
		recv_bit = 1'b1;
		clear_frame();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i]) begin
			t = '0;
			t.kind = KIND_VERDICT;
			t.verdict = script[i].v;
			t.response_control = script[i].ctl;
			t.response_check = script[i].chk;
			send_byte(script[i].b, script[i].typed, t);
		end
		while (line_bytes < LINE_TARGET) begin
			if (line_bytes >= LINE_TARGET - 300)
				quiet <= 1'b1;
			send_frame();
		end
		rx_valid <= 1'b0;
		while (frame_out_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("run: %0d line bytes, %0d random frames, %0d payload bytes checked", line_bytes,
			frames_sent, payload_seen);
		$display("run: replies new %0d, duplicate %0d, header error %0d, data error %0d",
			verdict_seen[VERDICT_NEW], verdict_seen[VERDICT_DUP], verdict_seen[VERDICT_HDR_ERR],
			verdict_seen[VERDICT_DATA_ERR]);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/hlfr_pkg.sv
rtl/hlfr_frame.sv
rtl/hlfr_outreg.sv
rtl/hdlc_like_frame_receiver.sv
tb/testbench.sv
